>>> rtl/core/aftl_pkg.sv
`default_nettype none
package aftl_pkg;
	localparam int MAX_FRAMES = 64;
	localparam int DUR_W = 24;
	localparam int TIME_W = 39;
	localparam int TOT_W = 40;

	localparam logic [1:0] REG_FRAMES = 2'd0;
	localparam logic [1:0] REG_DEFAULT = 2'd1;
	localparam logic [1:0] REG_LOOP = 2'd2;

	typedef enum logic [1:0] {
		FUNC_WRITE = 2'd0,
		FUNC_ELAPSED = 2'd1,
		FUNC_PROGRESS = 2'd2,
		FUNC_INDEX = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_SUMWAIT,
		S_MUL,
		S_MOD,
		S_SCAN,
		S_SCANWAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic sum_start;
		logic sum_step;
		logic mul;
		logic mod_step;
		logic scan_start;
		logic scan_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic is_write;
		logic empty;
		logic direct;
		logic need_mul;
		logic loop;
		logic sum_done;
		logic total_zero;
		logic past_end;
		logic mod_done;
		logic scan_done;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/core/aftl_ctrl.sv
`default_nettype none
module aftl_ctrl
	import aftl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_fire,
	input wire logic out_fire,
	input wire sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic out_valid
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != S_IDLE);
		out_valid = (state_q == S_OUT);
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					state_d = S_SUM;
				end
			end
			S_SUM: begin
				if (sts.is_write || sts.empty || sts.direct) begin
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.sum_start = 1'b1;
					state_d = S_SUMWAIT;
				end
			end
			S_SUMWAIT: begin
				if (sts.sum_done) begin
					if (sts.need_mul) state_d = S_MUL;
					else state_d = S_MOD;
				end else cmd.sum_step = 1'b1;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_MOD;
			end
			S_MOD: begin
				if (sts.total_zero || (!sts.loop && sts.past_end)) begin
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end else if (sts.loop && !sts.mod_done) cmd.mod_step = 1'b1;
				else begin
					cmd.scan_start = 1'b1;
					state_d = S_SCANWAIT;
				end
			end
			S_SCANWAIT: begin
				if (sts.scan_done) begin
					cmd.finish = 1'b1;
					state_d = S_OUT;
				end else cmd.scan_step = 1'b1;
			end
			S_OUT: if (out_fire) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_fire |=> out_valid)
		else $error("result dropped");
	a_load_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == S_IDLE)
		else $error("load outside idle");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> busy)
		else $error("load did not start");
endmodule
`default_nettype wire

>>> rtl/core/aftl_dp.sv
`default_nettype none
module aftl_dp
	import aftl_pkg::*;
(
	input wire logic clk,
	input wire cmd_t cmd,
	input wire logic [7:0] in_data_func_slot,
	input wire logic [DUR_W-1:0] in_dur,
	input wire logic [TOT_W-1:0] in_elapsed,
	input wire logic [16:0] in_prog,
	input wire logic [15:0] in_req,
	input wire logic [6:0] cfg_frames,
	input wire logic [DUR_W-1:0] cfg_default,
	input wire logic cfg_loop,
	input wire logic clr_valid,
	output sts_t sts,
	output logic [5:0] frame_index,
	output logic [1:0] status
);
	localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W = DUR_W + CW;
	localparam int T_W = (SUM_W + 17 > TIME_W + 1) ? SUM_W + 17 : TIME_W + 1;
	localparam int MOD_SH = TIME_W - 1;
	localparam int DIV_W = SUM_W + MOD_SH;

	logic [DUR_W-1:0] mem [MAX_FRAMES];
	logic [MAX_FRAMES-1:0] vld_q;
	logic [DUR_W-1:0] rd_q;
	logic rd_v_q;
	logic [1:0] func_q;
	logic [5:0] slot_q;
	logic [DUR_W-1:0] dur_q;
	logic [TOT_W-1:0] el_q;
	logic [16:0] prog_q;
	logic [15:0] req_q;
	logic [CW-1:0] count_q;
	logic [CW:0] ptr_q;
	logic [CW:0] rptr_q;
	logic [SUM_W-1:0] total_q, cur_q;
	logic [T_W-1:0] t_q;
	logic [DIV_W-1:0] div_q;
	logic [6:0] msh_q;
	logic [5:0] idx_q;
	logic [1:0] st_q;
	logic found_q;
	logic [6:0] cfgc;
	logic [DUR_W-1:0] eff;
	logic wr_ok;

	assign cfgc = (32'(cfg_frames) > MAX_FRAMES) ? 7'(MAX_FRAMES) : cfg_frames;
	assign wr_ok = 32'(slot_q) < MAX_FRAMES;
	assign eff = (rd_v_q && rd_q != '0) ? rd_q : cfg_default;

	always_ff @(posedge clk) begin
		if (cmd.finish && func_q == FUNC_WRITE && wr_ok) mem[slot_q[IW-1:0]] <= dur_q;
		rd_q <= mem[rptr_q[IW-1:0]];
		rd_v_q <= vld_q[rptr_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (clr_valid) vld_q <= '0;
		else if (cmd.finish && func_q == FUNC_WRITE && wr_ok) vld_q[slot_q[IW-1:0]] <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_data_func_slot[1:0];
			slot_q <= in_data_func_slot[7:2];
			dur_q <= in_dur;
			el_q <= in_elapsed;
			prog_q <= in_prog;
			req_q <= in_req;
			count_q <= CW'(cfgc);
		end
		if (cmd.sum_start || cmd.scan_start) begin
			ptr_q <= '0;
			rptr_q <= '0;
			cur_q <= '0;
			found_q <= 1'b0;
		end
		if (cmd.sum_start) begin
			total_q <= '0;
			t_q <= el_q[TOT_W-1] ? '0 : T_W'(el_q);
		end
		if (cmd.sum_step || cmd.scan_step) begin
			rptr_q <= rptr_q + 1'b1;
			if (rptr_q != (CW+1)'(0)) begin
				ptr_q <= ptr_q + 1'b1;
				if (cmd.sum_step) total_q <= total_q + SUM_W'(eff);
				else begin
					cur_q <= cur_q + SUM_W'(eff);
					if (!found_q && t_q < T_W'(cur_q + SUM_W'(eff))) begin
						found_q <= 1'b1;
						idx_q <= 6'(ptr_q);
					end
				end
			end
		end
		if (cmd.mul) t_q <= T_W'((T_W'(prog_q) * T_W'(total_q)) >> 16);
		if (cmd.sum_step && ptr_q == (CW+1)'(count_q) - 1'b1) begin
			div_q <= DIV_W'(total_q + SUM_W'(eff)) << MOD_SH;
			msh_q <= 7'(MOD_SH);
		end
		if (cmd.mod_step) begin
			if (DIV_W'(t_q) >= div_q) t_q <= t_q - T_W'(div_q);
			div_q <= div_q >> 1;
			msh_q <= msh_q - 1'b1;
		end
		if (cmd.finish) begin
			if (func_q == FUNC_WRITE) begin
				idx_q <= '0;
				st_q <= wr_ok ? ST_OK : ST_RANGE;
			end else if (count_q == '0) begin
				idx_q <= '0;
				st_q <= ST_EMPTY;
			end else begin
				st_q <= ST_OK;
				if (func_q == FUNC_INDEX)
					idx_q <= (32'(req_q) < 32'(count_q) - 1) ? 6'(req_q) : 6'(count_q - 1'b1);
				else if (func_q == FUNC_PROGRESS && prog_q == '0) idx_q <= '0;
				else if (func_q == FUNC_PROGRESS && prog_q[16]) idx_q <= 6'(count_q - 1'b1);
				else if (total_q == '0) begin
					if (func_q == FUNC_PROGRESS)
						idx_q <= 6'((32'(prog_q) * 32'(count_q)) >> 16);
					else idx_q <= '0;
				end else if (!found_q) idx_q <= 6'(count_q - 1'b1);
			end
		end
	end

	assign sts.is_write = (func_q == FUNC_WRITE);
	assign sts.empty = (count_q == '0);
	assign sts.direct = (func_q == FUNC_INDEX) ||
		(func_q == FUNC_PROGRESS && (prog_q == '0 || prog_q[16]));
	assign sts.need_mul = (func_q == FUNC_PROGRESS) && total_q != '0;
	assign sts.loop = cfg_loop;
	assign sts.sum_done = (ptr_q == (CW+1)'(count_q));
	assign sts.total_zero = (total_q == '0);
	assign sts.past_end = t_q >= T_W'(total_q);
	assign sts.mod_done = (msh_q == 7'h7f);
	assign sts.scan_done = found_q || (ptr_q == (CW+1)'(count_q));
	assign frame_index = idx_q;
	assign status = st_q;
endmodule
`default_nettype wire

>>> rtl/core/animation_frame_time_lookup_core.sv
// path: for writes, index queries, empty sequence and progress at 0 or full, m_tvalid rises
// after the S_SUM state; time queries walk the table in S_SUMWAIT, then pass S_MUL for
// progress, S_MOD (repeated modulo steps with loop_enable) and the S_SCANWAIT scan
// handshake: one beat in flight, next input beat accepted in the cycle after the result is taken
// reset: arst_n clears control and config, valid bits clear while clr_q is high, with s_tready
// low until clr_q drops after release; slots without a valid nonzero entry read as the default
`default_nettype none
module animation_frame_time_lookup_core
	import aftl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	// func, frame_slot, duration_us, elapsed_us, progress_q16, requested_index
	input wire logic [111:0] s_tdata,
	output logic m_tvalid,
	input wire logic m_tready,
	// frame_index, status
	output logic [7:0] m_tdata,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [23:0] cfg_data
);
	cmd_t cmd;
	sts_t sts;
	logic busy;
	logic [6:0] frames_q;
	logic [DUR_W-1:0] def_q;
	logic loop_q;
	logic clr_q;
	logic [5:0] fi;
	logic [1:0] st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= '0;
			def_q <= '0;
			loop_q <= 1'b0;
			clr_q <= 1'b1;
		end else begin
			clr_q <= 1'b0;
			if (cfg_we && cfg_index == REG_FRAMES) frames_q <= cfg_data[6:0];
			if (cfg_we && cfg_index == REG_DEFAULT) def_q <= cfg_data;
			if (cfg_we && cfg_index == REG_LOOP) loop_q <= cfg_data[0];
		end
	end

	assign s_tready = !busy && !clr_q;

	aftl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(s_tvalid && s_tready),
		.out_fire(m_tvalid && m_tready), .sts(sts), .cmd(cmd),
		.busy(busy), .out_valid(m_tvalid)
	);

	aftl_dp u_dp (
		.clk(clk), .cmd(cmd), .in_data_func_slot(s_tdata[7:0]),
		.in_dur(s_tdata[31:8]), .in_elapsed(s_tdata[71:32]),
		.in_prog(s_tdata[88:72]), .in_req(s_tdata[104:89]),
		.cfg_frames(frames_q), .cfg_default(def_q), .cfg_loop(loop_q),
		.clr_valid(clr_q), .sts(sts), .frame_index(fi), .status(st)
	);

	assign m_tdata = {st, fi};
endmodule
`default_nettype wire
